// File: hdl/hcmb_pkg.sv
`default_nettype none
package hcmb_pkg;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_FRAME = 2'd2,
    REQ_IRQ   = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    OP_CART_RD,
    OP_CART_WR,
    OP_RD,
    OP_WR,
    OP_WR_ECHO,
    OP_NOP,
    OP_FRAME,
    OP_IRQ,
    OP_DIV,
    OP_JOY_WR,
    OP_DMA,
    OP_DMA_CART
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [3:0]  keys_hi;
    logic [3:0]  keys_lo;
  } cmd_t;

  localparam logic [15:0] JOYP_ADDR = 16'hff00;
  localparam logic [15:0] DIV_ADDR  = 16'hff04;
  localparam logic [15:0] IF_ADDR   = 16'hff0f;
  localparam logic [15:0] LY_ADDR   = 16'hff44;
  localparam logic [15:0] DMA_ADDR  = 16'hff46;
  localparam logic [15:0] OAM_BASE  = 16'hfe00;
  localparam logic [15:0] OAM_LAST  = 16'hfe9f;
  localparam logic [15:0] ECHO_OFS  = 16'h2000;
  localparam logic [15:0] ECHO_LAST = 16'hddff;
  localparam logic [15:0] ECHO_HI   = 16'hfdff;
  localparam logic [14:0] IO_FIRST  = 15'h7f10;
  localparam int unsigned IO_COUNT  = 58;

  function automatic logic is_cart(input logic [15:0] a);
    return (a[15:13] <= 3'd3) || (a[15:13] == 3'd5);
  endfunction

  function automatic logic [7:0] io_init(input logic [5:0] i);
    logic [7:0] v;
    v = 8'h00;
    unique case (i)
      6'h00: v = 8'h80; 6'h01: v = 8'hbf; 6'h02: v = 8'hf3; 6'h04: v = 8'hbf;
      6'h06: v = 8'h3f; 6'h09: v = 8'hbf; 6'h0a: v = 8'h7f; 6'h0b: v = 8'hff;
      6'h0c: v = 8'h9f; 6'h0d: v = 8'hbf; 6'h0e: v = 8'hbf; 6'h10: v = 8'hff;
      6'h13: v = 8'hbf; 6'h14: v = 8'h77; 6'h15: v = 8'hf3; 6'h16: v = 8'hf1;
      6'h30: v = 8'h91; 6'h37: v = 8'hfc; 6'h38: v = 8'hff; 6'h39: v = 8'hff;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: hdl/hcmb_ram.sv
`default_nettype none
module hcmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hdl/hcmb_front.sv
`default_nettype none
module hcmb_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    in_req_type,
  input  wire logic [15:0]   in_addr,
  input  wire logic [7:0]    in_wdata,
  input  wire logic          in_vram_open,
  input  wire logic          in_oam_open,
  input  wire logic [3:0]    in_keys_sel_hi,
  input  wire logic [3:0]    in_keys_sel_lo,
  output logic               q_valid,
  output hcmb_pkg::cmd_t     q_cmd,
  input  wire logic          q_pop
);
  hcmb_pkg::cmd_t cmd;
  hcmb_pkg::cmd_t buf_r [2];
  logic [1:0] cnt_r;
  logic rd_r, wr_r;
  logic push, pop;

  always_comb begin
    cmd.addr = in_addr;
    cmd.wdata = in_wdata;
    cmd.keys_hi = in_keys_sel_hi;
    cmd.keys_lo = in_keys_sel_lo;
    cmd.op = hcmb_pkg::OP_NOP;
    unique case (hcmb_pkg::req_t'(in_req_type))
      hcmb_pkg::REQ_READ:
        cmd.op = hcmb_pkg::is_cart(in_addr) ? hcmb_pkg::OP_CART_RD : hcmb_pkg::OP_RD;
      hcmb_pkg::REQ_FRAME: cmd.op = hcmb_pkg::OP_FRAME;
      hcmb_pkg::REQ_IRQ: begin
        cmd.op = hcmb_pkg::OP_IRQ;
        cmd.addr = hcmb_pkg::IF_ADDR;
      end
      default: begin
        priority if (in_addr[15:12] <= 4'd7 || in_addr[15:13] == 3'd5) begin
          cmd.op = hcmb_pkg::OP_CART_WR;
        end else if (in_addr[15:13] == 3'd4) begin
          cmd.op = in_vram_open ? hcmb_pkg::OP_WR : hcmb_pkg::OP_NOP;
        end else if (in_addr[15:13] == 3'd6) begin
          cmd.op = (in_addr <= hcmb_pkg::ECHO_LAST) ? hcmb_pkg::OP_WR_ECHO : hcmb_pkg::OP_WR;
        end else if (in_addr <= hcmb_pkg::ECHO_HI) begin
          cmd.op = hcmb_pkg::OP_WR_ECHO;
        end else if (in_addr <= hcmb_pkg::OAM_LAST) begin
          cmd.op = in_oam_open ? hcmb_pkg::OP_WR : hcmb_pkg::OP_NOP;
        end else if (in_addr == hcmb_pkg::JOYP_ADDR) begin
          cmd.op = hcmb_pkg::OP_JOY_WR;
        end else if (in_addr == hcmb_pkg::DIV_ADDR) begin
          cmd.op = hcmb_pkg::OP_DIV;
        end else if (in_addr == hcmb_pkg::IF_ADDR) begin
          cmd.op = hcmb_pkg::OP_IRQ;
        end else if (in_addr == hcmb_pkg::LY_ADDR) begin
          cmd.op = hcmb_pkg::OP_NOP;
        end else if (in_addr == hcmb_pkg::DMA_ADDR) begin
          if (!in_oam_open) begin
            cmd.op = hcmb_pkg::OP_NOP;
          end else if (hcmb_pkg::is_cart({in_wdata, 8'h00})) begin
            cmd.op = hcmb_pkg::OP_DMA_CART;
          end else begin
            cmd.op = hcmb_pkg::OP_DMA;
          end
        end else begin
          cmd.op = hcmb_pkg::OP_WR;
        end
      end
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign pop = q_pop && q_valid;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = buf_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      if (push) begin
        buf_r[wr_r] <= cmd;
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// File: hdl/hcmb_back.sv
`default_nettype none
module hcmb_back #(
  parameter int DMA_BYTES = 160
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  wire hcmb_pkg::cmd_t q_cmd,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_rdata,
  output logic             out_cart_access,
  output logic [15:0]      out_cart_addr,
  output logic [7:0]       out_cart_data,
  output logic             out_cpu_irq_notify,
  output logic             out_div_reset,
  output logic             out_lag_frame,
  output logic             out_dma_cart_source,
  output logic             busy
);
  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_ECHO, S_DMA_RD, S_DMA_WR
  } state_t;

  state_t state_r;
  logic [14:0] clr_r;
  logic [7:0] dma_src_r;
  logic [7:0] dma_i_r;
  logic joy_flag_r;
  hcmb_pkg::cmd_t cur_r;

  logic we;
  logic [14:0] waddr, raddr;
  logic [7:0] wdat, rdat;
  logic [15:0] src_a;
  logic [7:0] joy_val;
  logic [5:0] io_idx;
  logic [14:0] io_ofs;

  hcmb_ram #(.WIDTH(8), .DEPTH(32768)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdat), .raddr(raddr), .rdata(rdat)
  );

  assign src_a = {dma_src_r, dma_i_r};
  assign io_ofs = clr_r - hcmb_pkg::IO_FIRST;
  assign io_idx = io_ofs[5:0];
  assign joy_val = rdat[5] ? {4'h2, cur_r.keys_hi} : {4'h1, cur_r.keys_lo};
  assign busy = (state_r != S_IDLE);
  assign q_pop = (state_r == S_IDLE) && q_valid && !out_valid;

  always_comb begin
    we = 1'b0;
    waddr = q_cmd.addr[14:0];
    wdat = q_cmd.wdata;
    raddr = q_cmd.addr[14:0];
    unique case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        waddr = clr_r;
        wdat = (clr_r >= hcmb_pkg::IO_FIRST && io_ofs < 15'(hcmb_pkg::IO_COUNT))
               ? hcmb_pkg::io_init(io_idx) : 8'h00;
      end
      S_IDLE: begin
        if (q_pop) begin
          unique case (q_cmd.op)
            hcmb_pkg::OP_WR, hcmb_pkg::OP_WR_ECHO, hcmb_pkg::OP_IRQ: we = 1'b1;
            hcmb_pkg::OP_DIV: begin
              we = 1'b1;
              wdat = 8'h00;
            end
            hcmb_pkg::OP_JOY_WR: begin
              we = 1'b1;
              wdat = q_cmd.wdata | 8'h0f;
            end
            hcmb_pkg::OP_DMA: raddr = {q_cmd.wdata[6:0], 8'h00};
            default: we = 1'b0;
          endcase
        end
      end
      S_ECHO: begin
        we = 1'b1;
        waddr = cur_r.addr[13] ? cur_r.addr[14:0] - hcmb_pkg::ECHO_OFS[14:0]
                               : cur_r.addr[14:0] + hcmb_pkg::ECHO_OFS[14:0];
        wdat = cur_r.wdata;
      end
      S_DMA_RD: raddr = src_a[14:0];
      S_DMA_WR: begin
        we = 1'b1;
        waddr = hcmb_pkg::OAM_BASE[14:0] + 15'(dma_i_r);
        wdat = (src_a == hcmb_pkg::JOYP_ADDR) ? joy_val : rdat;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      out_valid <= 1'b0;
      joy_flag_r <= 1'b0;
      dma_i_r <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 15'd1;
          if (&clr_r) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            cur_r <= q_cmd;
            out_rdata <= 8'h00;
            out_cart_access <= 1'b0;
            out_cart_addr <= 16'h0000;
            out_cart_data <= 8'h00;
            out_cpu_irq_notify <= 1'b0;
            out_div_reset <= 1'b0;
            out_lag_frame <= 1'b0;
            out_dma_cart_source <= 1'b0;
            dma_src_r <= q_cmd.wdata;
            dma_i_r <= '0;
            unique case (q_cmd.op)
              hcmb_pkg::OP_CART_RD: begin
                out_cart_access <= 1'b1;
                out_cart_addr <= q_cmd.addr;
                out_valid <= 1'b1;
              end
              hcmb_pkg::OP_CART_WR: begin
                out_cart_access <= 1'b1;
                out_cart_addr <= q_cmd.addr;
                out_cart_data <= q_cmd.wdata;
                out_valid <= 1'b1;
              end
              hcmb_pkg::OP_RD: state_r <= S_READ;
              hcmb_pkg::OP_WR_ECHO: state_r <= S_ECHO;
              hcmb_pkg::OP_FRAME: begin
                out_lag_frame <= ~joy_flag_r;
                joy_flag_r <= 1'b0;
                out_valid <= 1'b1;
              end
              hcmb_pkg::OP_IRQ: begin
                out_cpu_irq_notify <= 1'b1;
                out_valid <= 1'b1;
              end
              hcmb_pkg::OP_DIV: begin
                out_cpu_irq_notify <= 1'b1;
                out_div_reset <= 1'b1;
                out_valid <= 1'b1;
              end
              hcmb_pkg::OP_DMA_CART: begin
                out_dma_cart_source <= 1'b1;
                out_valid <= 1'b1;
              end
              hcmb_pkg::OP_DMA: state_r <= S_DMA_WR;
              default: out_valid <= 1'b1;
            endcase
          end
        end
        S_READ: begin
          if (cur_r.addr == hcmb_pkg::JOYP_ADDR) begin
            out_rdata <= joy_val;
            joy_flag_r <= 1'b1;
          end else begin
            out_rdata <= rdat;
          end
          out_valid <= 1'b1;
          state_r <= S_IDLE;
        end
        S_ECHO: begin
          out_valid <= 1'b1;
          state_r <= S_IDLE;
        end
        S_DMA_RD: state_r <= S_DMA_WR;
        S_DMA_WR: begin
          if (src_a == hcmb_pkg::JOYP_ADDR) begin
            joy_flag_r <= 1'b1;
          end
          dma_i_r <= dma_i_r + 8'd1;
          if (dma_i_r == 8'(DMA_BYTES - 1)) begin
            out_valid <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_DMA_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hdl/handheld_console_memory_bus.sv
`default_nettype none
// Memory bus of a handheld console: one transaction in, one result out.
// After reset a clearing pass over all 32768 RAM addresses loads the internal
// RAM (zeros plus power-on I/O values); at most two transactions are queued
// meanwhile and none is carried out. Cartridge accesses, frame-end queries,
// interrupt requests and gated or plain writes complete in the idle state;
// reads and echo writes also go through S_READ or S_ECHO (registered RAM read,
// one write port). An OAM DMA does one RAM read and one write per byte.
// A two-entry queue decouples the decoder from the execution unit.
module handheld_console_memory_bus #(
  parameter int DMA_BYTES = 160
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [15:0] in_addr,
  input  wire logic [7:0]  in_wdata,
  input  wire logic        in_vram_open,
  input  wire logic        in_oam_open,
  input  wire logic [3:0]  in_keys_sel_hi,
  input  wire logic [3:0]  in_keys_sel_lo,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_rdata,
  output logic             out_cart_access,
  output logic [15:0]      out_cart_addr,
  output logic [7:0]       out_cart_data,
  output logic             out_cpu_irq_notify,
  output logic             out_div_reset,
  output logic             out_lag_frame,
  output logic             out_dma_cart_source
);
  logic q_valid, q_pop, busy, fe_ready;
  hcmb_pkg::cmd_t q_cmd;

  assign in_ready = fe_ready;

  hcmb_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(fe_ready),
    .in_req_type(in_req_type), .in_addr(in_addr), .in_wdata(in_wdata),
    .in_vram_open(in_vram_open), .in_oam_open(in_oam_open),
    .in_keys_sel_hi(in_keys_sel_hi), .in_keys_sel_lo(in_keys_sel_lo),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
  );

  hcmb_back #(.DMA_BYTES(DMA_BYTES)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_rdata(out_rdata),
    .out_cart_access(out_cart_access), .out_cart_addr(out_cart_addr),
    .out_cart_data(out_cart_data), .out_cpu_irq_notify(out_cpu_irq_notify),
    .out_div_reset(out_div_reset), .out_lag_frame(out_lag_frame),
    .out_dma_cart_source(out_dma_cart_source), .busy(busy)
  );

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !out_valid && q_valid) else $error("pop while result pending");
  a_div_irq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_reset |-> out_cpu_irq_notify) else $error("div without irq");
  a_cart_rd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cart_access |-> out_rdata == 8'h00) else $error("cart read data");
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !q_pop) else $error("pop while busy");
`endif
endmodule
`default_nettype wire

// File: verif/handheld_console_memory_bus_tb.sv
module handheld_console_memory_bus_tb;

  typedef struct packed {
    logic [7:0]  rdata;
    logic        cart_access;
    logic [15:0] cart_addr;
    logic [7:0]  cart_data;
    logic        irq_notify;
    logic        div_reset;
    logic        lag_frame;
    logic        dma_cart_source;
  } bus_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_req_type;
  logic [15:0] in_addr;
  logic [7:0]  in_wdata;
  logic        in_vram_open;
  logic        in_oam_open;
  logic [3:0]  in_keys_sel_hi;
  logic [3:0]  in_keys_sel_lo;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_rdata;
  logic        out_cart_access;
  logic [15:0] out_cart_addr;
  logic [7:0]  out_cart_data;
  logic        out_cpu_irq_notify;
  logic        out_div_reset;
  logic        out_lag_frame;
  logic        out_dma_cart_source;

  handheld_console_memory_bus dut (.*);

  logic [7:0]  shadow_mem [0:32767];
  logic        joy_polled;
  bus_result_t expected_q[$];
  int          errors = 0;
  longint      cycle_count = 0;
  int          stall_mode;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] mem_rd(input logic [15:0] a, input logic [3:0] hi,
                                        input logic [3:0] lo);
    if (a == hcmb_pkg::JOYP_ADDR) begin
      joy_polled = 1'b1;
      return shadow_mem[a[14:0]][5] ? (8'h20 + {4'h0, hi}) : (8'h10 + {4'h0, lo});
    end
    return shadow_mem[a[14:0]];
  endfunction

  function automatic bus_result_t predict_access(input logic [1:0] rt, input logic [15:0] a,
      input logic [7:0] d, input logic vo, input logic oo, input logic [3:0] hi,
      input logic [3:0] lo);
    bus_result_t r;
    logic [15:0] src;
    r = '0;
    if (rt == hcmb_pkg::REQ_READ) begin
      if (hcmb_pkg::is_cart(a)) begin
        r.cart_access = 1'b1;
        r.cart_addr = a;
      end else begin
        r.rdata = mem_rd(a, hi, lo);
      end
    end else if (rt == hcmb_pkg::REQ_FRAME) begin
      r.lag_frame = !joy_polled;
      joy_polled = 1'b0;
    end else if (rt == hcmb_pkg::REQ_IRQ) begin
      shadow_mem[hcmb_pkg::IF_ADDR[14:0]] = d;
      r.irq_notify = 1'b1;
    end else if (a[15:12] <= 4'h7 || a[15:12] == 4'ha || a[15:12] == 4'hb) begin
      r.cart_access = 1'b1;
      r.cart_addr = a;
      r.cart_data = d;
    end else if (a[15:12] == 4'h8 || a[15:12] == 4'h9) begin
      if (vo) shadow_mem[a[14:0]] = d;
    end else if (a[15:12] == 4'hc || a[15:12] == 4'hd) begin
      shadow_mem[a[14:0]] = d;
      if (a <= hcmb_pkg::ECHO_LAST) shadow_mem[a[14:0] + 15'h2000] = d;
    end else if (a <= hcmb_pkg::ECHO_HI) begin
      shadow_mem[a[14:0]] = d;
      shadow_mem[a[14:0] - 15'h2000] = d;
    end else if (a <= hcmb_pkg::OAM_LAST) begin
      if (oo) shadow_mem[a[14:0]] = d;
    end else if (a == hcmb_pkg::JOYP_ADDR) begin
      shadow_mem[a[14:0]] = d | 8'h0f;
    end else if (a == hcmb_pkg::DIV_ADDR) begin
      shadow_mem[a[14:0]] = 8'h00;
      r.div_reset = 1'b1;
      r.irq_notify = 1'b1;
    end else if (a == hcmb_pkg::IF_ADDR) begin
      shadow_mem[a[14:0]] = d;
      r.irq_notify = 1'b1;
    end else if (a == hcmb_pkg::LY_ADDR) begin
    end else if (a == hcmb_pkg::DMA_ADDR) begin
      if (oo) begin
        src = {d, 8'h00};
        if (hcmb_pkg::is_cart(src)) r.dma_cart_source = 1'b1;
        else
          for (int i = 0; i < 160; i++)
            shadow_mem[hcmb_pkg::OAM_BASE[14:0] + i[14:0]] = mem_rd(src + i[15:0], hi, lo);
      end
    end else begin
      shadow_mem[a[14:0]] = d;
    end
    return r;
  endfunction

  task automatic send_access(input logic [1:0] rt, input logic [15:0] a, input logic [7:0] d,
                             input logic vo, input logic oo, input logic [3:0] hi,
                             input logic [3:0] lo);
    in_valid <= 1'b1;
    in_req_type <= rt;
    in_addr <= a;
    in_wdata <= d;
    in_vram_open <= vo;
    in_oam_open <= oo;
    in_keys_sel_hi <= hi;
    in_keys_sel_lo <= lo;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(predict_access(rt, a, d, vo, oo, hi, lo));
  endtask

  task automatic idle_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic send_rand(input logic [1:0] rt, input logic [15:0] a, input logic [7:0] d);
    send_access(rt, a, d, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ~out_ready | ($urandom_range(0, 1) == 1);
    endcase
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        bus_result_t e;
        e = expected_q.pop_front();
        if (out_rdata !== e.rdata) begin
          $error("rdata exp %0h got %0h", e.rdata, out_rdata); errors++; end
        if (out_cart_access !== e.cart_access) begin
          $error("cart_access exp %0h got %0h", e.cart_access, out_cart_access); errors++; end
        if (out_cart_addr !== e.cart_addr) begin
          $error("cart_addr exp %0h got %0h", e.cart_addr, out_cart_addr); errors++; end
        if (out_cart_data !== e.cart_data) begin
          $error("cart_data exp %0h got %0h", e.cart_data, out_cart_data); errors++; end
        if (out_cpu_irq_notify !== e.irq_notify) begin
          $error("cpu_irq_notify exp %0h got %0h", e.irq_notify, out_cpu_irq_notify);
          errors++; end
        if (out_div_reset !== e.div_reset) begin
          $error("div_reset exp %0h got %0h", e.div_reset, out_div_reset); errors++; end
        if (out_lag_frame !== e.lag_frame) begin
          $error("lag_frame exp %0h got %0h", e.lag_frame, out_lag_frame); errors++; end
        if (out_dma_cart_source !== e.dma_cart_source) begin
          $error("dma_cart_source exp %0h got %0h", e.dma_cart_source, out_dma_cart_source);
          errors++; end
      end
    end
  end

  task automatic test_directed();
    send_access(hcmb_pkg::REQ_READ, 16'hff40, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
    send_access(hcmb_pkg::REQ_READ, 16'h0000, 8'hff, 1'b1, 1'b1, 4'hf, 4'hf);
    send_access(hcmb_pkg::REQ_WRITE, 16'hbfff, 8'hff, 1'b0, 1'b0, 4'h0, 4'h0);
    send_access(hcmb_pkg::REQ_WRITE, 16'h8000, 8'h5a, 1'b0, 1'b1, 4'h0, 4'h0);
    send_access(hcmb_pkg::REQ_WRITE, 16'h9fff, 8'ha5, 1'b1, 1'b0, 4'h0, 4'h0);
    send_access(hcmb_pkg::REQ_READ, 16'h8000, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
    send_access(hcmb_pkg::REQ_READ, 16'h9fff, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
    send_access(hcmb_pkg::REQ_WRITE, 16'hddff, 8'h11, 1'b0, 1'b0, 4'h0, 4'h0);
    send_access(hcmb_pkg::REQ_WRITE, 16'hde00, 8'h22, 1'b0, 1'b0, 4'h0, 4'h0);
    send_access(hcmb_pkg::REQ_WRITE, 16'he000, 8'h33, 1'b0, 1'b0, 4'h0, 4'h0);
    send_access(hcmb_pkg::REQ_READ, 16'hfdff, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
    send_access(hcmb_pkg::REQ_READ, 16'hc000, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
    send_access(hcmb_pkg::REQ_WRITE, 16'hfe9f, 8'h44, 1'b0, 1'b0, 4'h0, 4'h0);
    send_access(hcmb_pkg::REQ_WRITE, 16'hfe00, 8'h55, 1'b0, 1'b1, 4'h0, 4'h0);
    send_access(hcmb_pkg::REQ_FRAME, 16'h0000, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
    send_access(hcmb_pkg::REQ_READ, hcmb_pkg::JOYP_ADDR, 8'h00, 1'b0, 1'b0, 4'h9, 4'h6);
    send_access(hcmb_pkg::REQ_WRITE, hcmb_pkg::JOYP_ADDR, 8'h20, 1'b0, 1'b0, 4'h0, 4'h0);
    send_access(hcmb_pkg::REQ_READ, hcmb_pkg::JOYP_ADDR, 8'h00, 1'b0, 1'b0, 4'h9, 4'h6);
    send_access(hcmb_pkg::REQ_FRAME, 16'hffff, 8'hff, 1'b1, 1'b1, 4'hf, 4'hf);
    send_access(hcmb_pkg::REQ_WRITE, hcmb_pkg::DIV_ADDR, 8'h7e, 1'b0, 1'b0, 4'h0, 4'h0);
    send_access(hcmb_pkg::REQ_WRITE, hcmb_pkg::IF_ADDR, 8'he1, 1'b0, 1'b0, 4'h0, 4'h0);
    send_access(hcmb_pkg::REQ_IRQ, 16'h1234, 8'h1f, 1'b0, 1'b0, 4'h0, 4'h0);
    send_access(hcmb_pkg::REQ_WRITE, hcmb_pkg::LY_ADDR, 8'h99, 1'b0, 1'b0, 4'h0, 4'h0);
    send_access(hcmb_pkg::REQ_WRITE, hcmb_pkg::DMA_ADDR, 8'hc0, 1'b1, 1'b1, 4'h3, 4'hc);
    send_access(hcmb_pkg::REQ_WRITE, hcmb_pkg::DMA_ADDR, 8'h40, 1'b1, 1'b1, 4'h0, 4'h0);
    send_access(hcmb_pkg::REQ_WRITE, hcmb_pkg::DMA_ADDR, 8'hff, 1'b0, 1'b1, 4'h5, 4'ha);
    send_access(hcmb_pkg::REQ_WRITE, hcmb_pkg::DMA_ADDR, 8'h80, 1'b0, 1'b0, 4'h0, 4'h0);
    send_access(hcmb_pkg::REQ_READ, 16'hfe00, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
    send_access(hcmb_pkg::REQ_WRITE, 16'hffff, 8'hff, 1'b1, 1'b1, 4'hf, 4'hf);
  endtask

  function automatic logic [15:0] pick_addr();
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'h8000 | 16'($urandom_range(0, 15));
      2: return 16'hc000 | 16'($urandom_range(0, 15));
      3: return 16'he000 | 16'($urandom_range(0, 15));
      4: return 16'hfe00 | 16'($urandom_range(0, 255));
      5: return 16'hff00 | 16'($urandom_range(0, 255));
      6: return hcmb_pkg::JOYP_ADDR;
      7: return hcmb_pkg::DMA_ADDR;
      8: return 16'hdde0 | 16'($urandom_range(0, 63));
      default: return 16'hff80 | 16'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic test_random(input int count);
    int burst;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 2) != 0) idle_sender();
        burst = $urandom_range(1, 20);
      end
      burst--;
      if (n == count / 2) drain();
      if (n % 100 == 0) stall_mode = $urandom_range(0, 2);
      send_rand(2'($urandom_range(0, 3)), pick_addr(), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    stall_mode = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = '0;
    in_addr = '0;
    in_wdata = '0;
    in_vram_open = 1'b0;
    in_oam_open = 1'b0;
    in_keys_sel_hi = '0;
    in_keys_sel_lo = '0;
    joy_polled = 1'b0;
    for (int i = 0; i < 32768; i++) shadow_mem[i] = 8'h00;
    for (int i = 0; i < hcmb_pkg::IO_COUNT; i++)
      shadow_mem[hcmb_pkg::IO_FIRST + i[14:0]] = hcmb_pkg::io_init(i[5:0]);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(500);
    drain();
    repeat (400) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
